// ----- rtl/iupac_degenerate_pattern_search_assert.svh -----
// Assertion macros shared by the search RTL.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef IUPAC_DEGENERATE_PATTERN_SEARCH_ASSERT_SVH
`define IUPAC_DEGENERATE_PATTERN_SEARCH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IDPS_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define IDPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/idps_pkg.sv -----
// Types, codes and character-class functions for the IUPAC pattern search.
// No dependencies; used by idps_class_match and the top level.
`default_nettype none

package idps_pkg;

    localparam int NEEDLE_STORED = 32;
    localparam int LEN_W         = 7;
    localparam int COUNT_W       = 32;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_WORDS     = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_LENGTH   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_CHARS_0  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_CHARS_1  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_CHARS_2  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_CHARS_3  = 3'd4;

    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_BAD_CODE  = 2'd2;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_C = 8'h63;
    localparam logic [7:0] CH_G = 8'h67;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_U = 8'h75;
    localparam logic [7:0] CH_N = 8'h6E;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_Y = 8'h79;
    localparam logic [7:0] CH_S = 8'h73;
    localparam logic [7:0] CH_W = 8'h77;
    localparam logic [7:0] CH_K = 8'h6B;
    localparam logic [7:0] CH_M = 8'h6D;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_D = 8'h64;
    localparam logic [7:0] CH_H = 8'h68;
    localparam logic [7:0] CH_V = 8'h76;

    typedef struct packed {
        logic [7:0] hay_byte;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] match_start;
    } t_out_item;

    // Bases are one bit each: a, c, g, t from bit 0 upward.
    typedef struct packed {
        logic       any;
        logic       bad;
        logic [3:0] bases;
    } t_code_class;

    function automatic logic [7:0] fold_lower(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    function automatic logic [3:0] base_class(input logic [7:0] c);
        logic [3:0] r;
        unique case (fold_lower(c))
            CH_A:    r = 4'b0001;
            CH_C:    r = 4'b0010;
            CH_G:    r = 4'b0100;
            CH_T:    r = 4'b1000;
            default: r = 4'b0000;
        endcase
        return r;
    endfunction

    function automatic t_code_class code_class(input logic [7:0] c);
        t_code_class r;
        r = '{any: 1'b0, bad: 1'b0, bases: 4'b0000};
        unique case (fold_lower(c))
            CH_A:       r.bases = 4'b0001;
            CH_C:       r.bases = 4'b0010;
            CH_G:       r.bases = 4'b0100;
            CH_T, CH_U: r.bases = 4'b1000;
            CH_R:       r.bases = 4'b0101;
            CH_Y:       r.bases = 4'b1010;
            CH_S:       r.bases = 4'b0110;
            CH_W:       r.bases = 4'b1001;
            CH_K:       r.bases = 4'b1100;
            CH_M:       r.bases = 4'b0011;
            CH_B:       r.bases = 4'b1110;
            CH_D:       r.bases = 4'b1101;
            CH_H:       r.bases = 4'b1011;
            CH_V:       r.bases = 4'b0111;
            CH_N:       r.any   = 1'b1;
            default:    r.bad   = 1'b1;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/idps_class_match.sv -----
// Per-position needle decode and class test against one haystack byte.
// Depends on idps_pkg for the code and base class functions.
`default_nettype none

module idps_class_match #(
    parameter int MAX_NEEDLE = 32
) (
    input  wire logic [5:0]                             i_needle_length,
    input  wire logic [idps_pkg::NEEDLE_STORED*8-1:0]   i_needle_chars,
    input  wire logic [7:0]                             i_hay_byte,
    output logic [idps_pkg::LEN_W-1:0]                  o_used_len,
    output logic                                        o_bad,
    output logic [MAX_NEEDLE-1:0]                       o_accept,
    output logic [MAX_NEEDLE-1:0]                       o_last_sel
);
    import idps_pkg::*;

    logic [LEN_W-1:0]      used_len;
    logic [3:0]            hay_bases;
    logic [MAX_NEEDLE-1:0] bad_pos;

    assign used_len   = ({1'b0, i_needle_length} > LEN_W'(MAX_NEEDLE)) ?
                        LEN_W'(MAX_NEEDLE) : {1'b0, i_needle_length};
    assign hay_bases  = base_class(i_hay_byte);
    assign o_used_len = used_len;
    assign o_bad      = |bad_pos;

    for (genvar gi = 0; gi < MAX_NEEDLE; gi++) begin : g_pos
        logic [7:0]  pos_char;
        t_code_class pos_cls;
        logic        in_use;

        // Positions past the stored characters read as a zero byte.
        if (gi < NEEDLE_STORED) begin : g_stored
            assign pos_char = i_needle_chars[gi*8 +: 8];
        end else begin : g_blank
            assign pos_char = 8'h00;
        end

        assign pos_cls        = code_class(pos_char);
        assign in_use         = LEN_W'(gi) < used_len;
        assign bad_pos[gi]    = in_use & pos_cls.bad;
        assign o_accept[gi]   = in_use & ~pos_cls.bad &
                                (pos_cls.any | (|(pos_cls.bases & hay_bases)));
        assign o_last_sel[gi] = used_len == LEN_W'(gi + 1);
    end

endmodule

`default_nettype wire

// ----- rtl/iupac_degenerate_pattern_search.sv -----
// Path: a byte is held in the input register, then one update writes its result to the result register.
// Throughput: one haystack byte per cycle while no waiting result is stalled.
// The input side stalls only while its register is full and a waiting result is stalled.
// Reset (synchronous, active low) clears the needle registers, search state and valid flags.
// Depends on idps_pkg, idps_class_match and iupac_degenerate_pattern_search_assert.svh.
`default_nettype none

`include "iupac_degenerate_pattern_search_assert.svh"

module iupac_degenerate_pattern_search #(
    parameter int MAX_NEEDLE = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [idps_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [idps_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire idps_pkg::t_in_item               i_in_item,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output idps_pkg::t_out_item                   o_out_item
);
    import idps_pkg::*;

    logic [5:0]                  r_needle_length;
    logic [CFG_DATA_W-1:0]       r_needle_chars [CFG_WORDS];

    logic                        r_in_valid;
    t_in_item                    r_in_item;
    logic                        r_out_valid;
    t_out_item                   r_out_item;

    logic [MAX_NEEDLE-1:0]       r_pmv;
    logic [COUNT_W-1:0]          r_bytes_seen;
    logic                        r_answered;

    logic [MAX_NEEDLE-1:0]       n_pmv;
    logic [COUNT_W-1:0]          n_bytes_seen;
    logic                        n_answered;
    logic                        n_out_valid;
    t_out_item                   n_out_item;

    logic                        out_block;
    logic                        in_fire;
    logic                        step_fire;
    logic [LEN_W-1:0]            used_len;
    logic                        needle_bad;
    logic [MAX_NEEDLE-1:0]       accept;
    logic [MAX_NEEDLE-1:0]       last_sel;
    logic [MAX_NEEDLE:0]         shifted_full;
    logic [MAX_NEEDLE-1:0]       pmv_step;
    logic [COUNT_W-1:0]          bytes_inc;

    assign out_block  = r_out_valid & i_out_stall;
    assign o_in_stall = r_in_valid & out_block;
    assign in_fire    = i_in_valid & ~o_in_stall;
    assign step_fire  = r_in_valid & ~out_block;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    idps_class_match #(
        .MAX_NEEDLE (MAX_NEEDLE)
    ) u_class_match (
        .i_needle_length (r_needle_length),
        .i_needle_chars  ({r_needle_chars[3], r_needle_chars[2],
                           r_needle_chars[1], r_needle_chars[0]}),
        .i_hay_byte      (r_in_item.hay_byte),
        .o_used_len      (used_len),
        .o_bad           (needle_bad),
        .o_accept        (accept),
        .o_last_sel      (last_sel)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needle_length <= '0;
            for (int w = 0; w < CFG_WORDS; w++) begin
                r_needle_chars[w] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NEEDLE_LENGTH:  r_needle_length   <= i_cfg_wdata[5:0];
                CFG_NEEDLE_CHARS_0: r_needle_chars[0] <= i_cfg_wdata;
                CFG_NEEDLE_CHARS_1: r_needle_chars[1] <= i_cfg_wdata;
                CFG_NEEDLE_CHARS_2: r_needle_chars[2] <= i_cfg_wdata;
                CFG_NEEDLE_CHARS_3: r_needle_chars[3] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign shifted_full = {r_pmv, 1'b1};
    assign pmv_step     = shifted_full[MAX_NEEDLE-1:0] & accept;
    assign bytes_inc    = (r_bytes_seen == '1) ? r_bytes_seen : r_bytes_seen + 1'b1;

    always_comb begin
        n_pmv        = r_pmv;
        n_bytes_seen = r_bytes_seen;
        n_answered   = r_answered;
        n_out_valid  = out_block;
        n_out_item   = r_out_item;
        if (step_fire) begin
            n_out_valid = 1'b0;
            n_out_item  = '{status: ST_NOT_FOUND, match_start: '0};
            if (r_answered) begin
                if (r_in_item.is_last) begin
                    n_pmv        = '0;
                    n_bytes_seen = '0;
                    n_answered   = 1'b0;
                end
            end else begin
                n_bytes_seen = bytes_inc;
                if (needle_bad || used_len == '0) begin
                    n_out_valid       = 1'b1;
                    n_out_item.status = needle_bad ? ST_BAD_CODE : ST_FOUND;
                    n_answered        = 1'b1;
                end else begin
                    n_pmv = pmv_step;
                    if (|(pmv_step & last_sel)) begin
                        n_out_valid            = 1'b1;
                        n_out_item.status      = ST_FOUND;
                        n_out_item.match_start = r_bytes_seen -
                                                 {{(COUNT_W-LEN_W){1'b0}}, used_len} +
                                                 1'b1;
                        n_answered             = 1'b1;
                    end else if (r_in_item.is_last) begin
                        n_out_valid       = 1'b1;
                        n_out_item.status = ST_NOT_FOUND;
                    end
                end
                if (r_in_item.is_last) begin
                    n_pmv        = '0;
                    n_bytes_seen = '0;
                    n_answered   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pmv        <= '0;
            r_bytes_seen <= '0;
            r_answered   <= 1'b0;
        end else begin
            r_in_valid   <= in_fire | (r_in_valid & ~step_fire);
            r_out_valid  <= n_out_valid;
            r_pmv        <= n_pmv;
            r_bytes_seen <= n_bytes_seen;
            r_answered   <= n_answered;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_item <= i_in_item;
        end
        r_out_item <= n_out_item;
    end

    `IDPS_ASSERT_NEXT(a_last_clears, step_fire && r_in_item.is_last,
        r_bytes_seen == '0 && !r_answered && r_pmv == '0)
    `IDPS_ASSERT_NEXT(a_no_result_after_answer, step_fire && r_answered, !r_out_valid)
    `IDPS_ASSERT_NEXT(a_last_gives_result, step_fire && !r_answered && r_in_item.is_last,
        r_out_valid)
    `IDPS_ASSERT_IMPLY(a_answered_counts, r_answered, r_bytes_seen != '0)

endmodule

`default_nettype wire
